// ===== rtl/dmfm_pkg.sv =====
// Package for the dot matrix frame merger: sizes, register indexes, result type
// and the CRC-32 word update. No dependencies; used by every file in rtl/ but dmfm_ram.sv.

package dmfm_pkg;

  // Storage limits.
  localparam int MAX_PLANE_WORDS = 8192;
  localparam int MAX_LINE_WORDS  = 32;
  localparam int MAX_PLANES      = 4;

  localparam int POS_W   = $clog2(MAX_PLANE_WORDS);
  localparam int LW_W    = $clog2(MAX_LINE_WORDS);
  localparam int PLANE_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  // Configuration port.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANES         = 3'd0,
    REG_MERGE_SHIFT    = 3'd1,
    REG_OVERSAMPLING   = 3'd2,
    REG_WORDS_PER_LINE = 3'd3,
    REG_LINES          = 3'd4
  } cfg_reg_t;

  // Oversampling codes.
  localparam logic [1:0] OVS_TWO  = 2'd1;
  localparam logic [1:0] OVS_FOUR = 2'd2;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_CRC   = 1'b1;

  // Reflected CRC-32.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Output queue.
  localparam int OUT_DEPTH = 16;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  typedef struct packed {
    logic        kind;
    logic [31:0] data;
    logic        changed;
    logic        last;
  } result_t;

  // One 32-bit word into the CRC, least significant bit first, which is the
  // same as feeding its little-endian bytes. Linear, so it maps to an XOR net.
  function automatic logic [31:0] crc_word(input logic [31:0] crc_in,
                                           input logic [31:0] w);
    logic [31:0] c;
    c = crc_in;
    for (int i = 0; i < 32; i++) begin
      if (c[0] ^ w[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/dmfm_ram.sv =====
// Generic single-clock RAM: one write port and one read port with registered
// read data. No dependencies.

module dmfm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read (old data on a same-address collision).
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dot_matrix_frame_merger.sv =====
// Top level of the dot matrix frame merger: plane summing, sub-line merging,
// frame CRC and the output queue. Depends on dmfm_pkg and dmfm_ram.

// The block takes one raw word per clock cycle while raw_stall is low, and
// its results are registered through stages 1 to 3. That rate is set by the
// plane-sum memory, which does one read and one write per cycle; a word that
// hits the entry written in the cycle before gets the new value forwarded.
// Words of all but the last plane produce no result, a word of the last plane
// produces a pixel word once its sub-line group is complete, and the frame's
// final word produces that pixel word and then the checksum result. Results
// wait in a 16-entry queue that drains one per cycle when not stalled, so a
// short stall on the output side does not stop the input. Writes to registers
// 0 to 4 restart the frame in progress; write registers only while idle.

module dot_matrix_frame_merger (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration.
  input  logic                           cfg_write,
  input  logic [dmfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmfm_pkg::CFG_W-1:0]     cfg_data,
  // Raw word requests.
  input  logic                           raw_valid,
  output logic                           raw_stall,
  input  logic [31:0]                    raw_word,
  // Result requests.
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           kind,
  output logic [31:0]                    data,
  output logic                           changed,
  output logic                           last
);

  localparam int POS_W   = dmfm_pkg::POS_W;
  localparam int LW_W    = dmfm_pkg::LW_W;
  localparam int PLANE_W = dmfm_pkg::PLANE_W;
  localparam int M_W     = LW_W + 4;
  localparam int NEED_W  = dmfm_pkg::OUT_CNT_W + 1;

  // Configuration registers.
  logic [2:0] planes_per_frame;
  logic       merge_shift;
  logic [1:0] oversampling;
  logic [4:0] words_per_line;
  logic [6:0] lines;

  // Frame position counters.
  logic [POS_W-1:0]   word_position;
  logic [PLANE_W-1:0] plane_number;
  logic [1:0]         sub_line;
  logic [LW_W-1:0]    line_word;
  logic [6:0]         line_group;

  // Pipeline stages.
  logic               s1_valid;
  logic [POS_W-1:0]   s1_pos;
  logic [31:0]        s1_val;
  logic               s1_first;
  logic               s1_store;
  logic [1:0]         s1_sub;
  logic [LW_W-1:0]    s1_lw;
  logic               s1_frame_end;

  logic               s2_valid;
  logic [31:0]        s2_sum;
  logic [1:0]         s2_sub;
  logic [LW_W-1:0]    s2_lw;
  logic               s2_frame_end;

  logic               s3_valid;
  logic [31:0]        s3_word;
  logic               s3_frame_end;

  // Forwarding of the last plane-sum write.
  logic               fwd_valid;
  logic [POS_W-1:0]   fwd_addr;
  logic [31:0]        fwd_data;

  // CRC state.
  logic [31:0] running_crc;
  logic [31:0] previous_crc;

  // Line-sum registers, one per word of a line.
  logic [31:0] line_sum [dmfm_pkg::MAX_LINE_WORDS];

  // Output queue.
  dmfm_pkg::result_t              out_q [dmfm_pkg::OUT_DEPTH];
  logic [dmfm_pkg::OUT_PTR_W-1:0] rd_ptr;
  logic [dmfm_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [dmfm_pkg::OUT_CNT_W-1:0] out_count;

  // Derived frame geometry.
  logic [1:0]         f_sh;
  logic [1:0]         f_last;
  logic [PLANE_W-1:0] np_last;
  logic [6:0]         wpl_eff;
  logic [LW_W-1:0]    wpl_last;
  logic [M_W-1:0]     group_words;
  logic [6:0]         nl_last;

  // Handshake and stage-0 decisions.
  logic               accept;
  logic               pop;
  logic               line_end;
  logic               group_end;
  logic [POS_W:0]     pos_inc;
  logic               plane_end;
  logic               frame_end;
  logic [NEED_W-1:0]  need;

  // Stage logic.
  logic [31:0]        ram_rdata;
  logic [31:0]        s1_prior;
  logic [31:0]        s1_sum;
  logic [1:0]         s2_wsh;
  logic [31:0]        s2_part;
  logic [31:0]        s2_acc;
  logic               s2_emit;
  logic [31:0]        crc_next;
  logic [31:0]        crc_final;
  dmfm_pkg::result_t  pix_res;
  dmfm_pkg::result_t  crc_res;

  // Geometry from the registers, with the out-of-range codes folded in.
  always_comb begin
    case (oversampling)
      dmfm_pkg::OVS_TWO:  f_sh = 2'd1;
      dmfm_pkg::OVS_FOUR: f_sh = 2'd2;
      default:            f_sh = 2'd0;
    endcase
    f_last = 2'((3'd1 << f_sh) - 3'd1);

    if (planes_per_frame == 3'd0) begin
      np_last = '0;
    end else if (int'(planes_per_frame) > dmfm_pkg::MAX_PLANES) begin
      np_last = PLANE_W'(dmfm_pkg::MAX_PLANES - 1);
    end else begin
      np_last = PLANE_W'(planes_per_frame - 3'd1);
    end

    wpl_eff = (words_per_line == 5'd0) ? 7'd1 : {2'b00, words_per_line};
    if (int'(wpl_eff) > dmfm_pkg::MAX_LINE_WORDS) begin
      wpl_eff = 7'(dmfm_pkg::MAX_LINE_WORDS);
    end
    if (int'(wpl_eff) > (dmfm_pkg::MAX_PLANE_WORDS >> f_sh)) begin
      wpl_eff = 7'(dmfm_pkg::MAX_PLANE_WORDS >> f_sh);
    end
    wpl_last    = LW_W'(wpl_eff - 7'd1);
    group_words = M_W'({2'b00, wpl_eff} << f_sh);
    nl_last     = (lines == 7'd0) ? 7'd0 : lines - 7'd1;
  end

  // Stage 0: where the accepted word sits in the frame. A plane ends after
  // its last line group, or earlier when the next group would not fit.
  always_comb begin
    line_end  = (line_word == wpl_last);
    group_end = line_end && (sub_line == f_last);
    pos_inc   = (POS_W + 1)'(word_position) + (POS_W + 1)'(1);
    plane_end = group_end &&
                ((line_group == nl_last) ||
                 ((POS_W + 2)'(pos_inc) + (POS_W + 2)'(group_words) >
                  (POS_W + 2)'(dmfm_pkg::MAX_PLANE_WORDS)));
    frame_end = plane_end && (plane_number == np_last);
  end

  // Each stage and the new word may add two results; stall unless they fit.
  always_comb begin
    need = NEED_W'(out_count) + NEED_W'(2) +
           NEED_W'({s1_valid, 1'b0}) + NEED_W'({s2_valid, 1'b0}) +
           NEED_W'({s3_valid, 1'b0});
  end

  assign raw_stall = (need > NEED_W'(dmfm_pkg::OUT_DEPTH));
  assign accept    = raw_valid && !raw_stall;

  // Configuration registers and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      planes_per_frame <= 3'd1;
      merge_shift      <= 1'b0;
      oversampling     <= 2'd0;
      words_per_line   <= 5'd8;
      lines            <= 7'd32;
      word_position    <= '0;
      plane_number     <= '0;
      sub_line         <= '0;
      line_word        <= '0;
      line_group       <= '0;
    end else if (cfg_write) begin
      case (dmfm_pkg::cfg_reg_t'(cfg_index))
        dmfm_pkg::REG_PLANES:         planes_per_frame <= cfg_data[2:0];
        dmfm_pkg::REG_MERGE_SHIFT:    merge_shift      <= cfg_data[0];
        dmfm_pkg::REG_OVERSAMPLING:   oversampling     <= cfg_data[1:0];
        dmfm_pkg::REG_WORDS_PER_LINE: words_per_line   <= cfg_data[4:0];
        dmfm_pkg::REG_LINES:          lines            <= cfg_data[6:0];
        default: ;
      endcase
      if (int'(cfg_index) <= int'(dmfm_pkg::REG_LINES)) begin
        word_position <= '0;
        plane_number  <= '0;
        sub_line      <= '0;
        line_word     <= '0;
        line_group    <= '0;
      end
    end else if (accept) begin
      if (plane_end) begin
        word_position <= '0;
        sub_line      <= '0;
        line_word     <= '0;
        line_group    <= '0;
        plane_number  <= frame_end ? '0 : plane_number + PLANE_W'(1);
      end else begin
        word_position <= POS_W'(pos_inc);
        if (line_end) begin
          line_word <= '0;
          if (sub_line == f_last) begin
            sub_line   <= '0;
            line_group <= line_group + 7'd1;
          end else begin
            sub_line <= sub_line + 2'd1;
          end
        end else begin
          line_word <= line_word + LW_W'(1);
        end
      end
    end
  end

  // Plane-sum memory: read at the accepted word's position, written back
  // in the next cycle from stage 1.
  dmfm_ram #(
    .WIDTH(32),
    .DEPTH(dmfm_pkg::MAX_PLANE_WORDS)
  ) u_plane_ram (
    .clk  (clk),
    .we   (s1_valid && s1_store),
    .waddr(s1_pos),
    .wdata(s1_sum),
    .raddr(word_position),
    .rdata(ram_rdata)
  );

  // Stage 1 control and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_pos       <= word_position;
    s1_val       <= merge_shift ? (raw_word << plane_number) : raw_word;
    s1_first     <= (plane_number == '0);
    s1_store     <= (plane_number != np_last);
    s1_sub       <= sub_line;
    s1_lw        <= line_word;
    s1_frame_end <= frame_end;
  end

  // Stage 1: add this plane to the sum so far, taking the previous cycle's
  // write when it went to the same entry.
  always_comb begin
    s1_prior = (fwd_valid && (fwd_addr == s1_pos)) ? fwd_data : ram_rdata;
    s1_sum   = s1_first ? s1_val : s1_prior + s1_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      fwd_valid <= s1_valid && s1_store;
      s2_valid  <= s1_valid && !s1_store;
    end
    fwd_addr     <= s1_pos;
    fwd_data     <= s1_sum;
    s2_sum       <= s1_sum;
    s2_sub       <= s1_sub;
    s2_lw        <= s1_lw;
    s2_frame_end <= s1_frame_end;
  end

  // Stage 2: weight the sub-line (2,1 or 2,4,1,8, all powers of two) and
  // accumulate into the line-sum register of this word.
  always_comb begin
    case (f_sh)
      2'd1: s2_wsh = s2_sub[0] ? 2'd0 : 2'd1;
      2'd2: begin
        case (s2_sub)
          2'd0:    s2_wsh = 2'd1;
          2'd1:    s2_wsh = 2'd2;
          2'd2:    s2_wsh = 2'd0;
          default: s2_wsh = 2'd3;
        endcase
      end
      default: s2_wsh = 2'd0;
    endcase
    s2_part = s2_sum << s2_wsh;
    s2_acc  = (s2_sub == 2'd0) ? s2_part : line_sum[s2_lw] + s2_part;
    s2_emit = (s2_sub == f_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid && s2_emit;
    end
    if (s2_valid) begin
      line_sum[s2_lw] <= s2_acc;
    end
    s3_word      <= s2_acc;
    s3_frame_end <= s2_frame_end;
  end

  // Stage 3: CRC over the emitted words and the results of this word.
  always_comb begin
    crc_next  = dmfm_pkg::crc_word(running_crc, s3_word);
    crc_final = ~crc_next;

    pix_res.kind    = dmfm_pkg::KIND_PIXEL;
    pix_res.data    = s3_word;
    pix_res.changed = 1'b0;
    pix_res.last    = 1'b0;

    crc_res.kind    = dmfm_pkg::KIND_CRC;
    crc_res.data    = crc_final;
    crc_res.changed = (crc_final != previous_crc);
    crc_res.last    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc  <= dmfm_pkg::CRC_INIT;
      previous_crc <= '0;
    end else if (cfg_write) begin
      if (int'(cfg_index) <= int'(dmfm_pkg::REG_LINES)) begin
        running_crc <= dmfm_pkg::CRC_INIT;
      end
    end else if (s3_valid) begin
      if (s3_frame_end) begin
        running_crc  <= dmfm_pkg::CRC_INIT;
        previous_crc <= crc_final;
      end else begin
        running_crc <= crc_next;
      end
    end
  end

  // Output queue: up to two pushes and one pop per cycle.
  assign pop = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      out_count <= '0;
    end else begin
      rd_ptr    <= rd_ptr + dmfm_pkg::OUT_PTR_W'(pop);
      wr_ptr    <= wr_ptr + dmfm_pkg::OUT_PTR_W'(s3_valid) +
                   dmfm_pkg::OUT_PTR_W'(s3_valid && s3_frame_end);
      out_count <= out_count + dmfm_pkg::OUT_CNT_W'(s3_valid) +
                   dmfm_pkg::OUT_CNT_W'(s3_valid && s3_frame_end) -
                   dmfm_pkg::OUT_CNT_W'(pop);
    end
    if (s3_valid) begin
      out_q[wr_ptr] <= pix_res;
      if (s3_frame_end) begin
        out_q[wr_ptr + dmfm_pkg::OUT_PTR_W'(1)] <= crc_res;
      end
    end
  end

  assign result_valid = (out_count != '0);
  assign kind         = out_q[rd_ptr].kind;
  assign data         = out_q[rd_ptr].data;
  assign changed      = out_q[rd_ptr].changed;
  assign last         = out_q[rd_ptr].last;

endmodule

// ===== rtl/dmfm_checker.sv =====
// Port-level checker for the dot matrix frame merger, bound to the top level.
// Depends on dmfm_pkg.

module dmfm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           raw_valid,
  input logic                           raw_stall,
  input logic [31:0]                    raw_word,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic                           kind,
  input logic [31:0]                    data,
  input logic                           changed,
  input logic                           last
);

  // A stalled raw word request holds its payload.
  a_raw_hold: assert property (@(posedge clk) disable iff (rst)
    raw_valid && raw_stall |=> raw_valid && $stable(raw_word))
    else $error("stalled raw word request changed");

  // A stalled result request holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(kind) && $stable(data) &&
      $stable(changed) && $stable(last))
    else $error("stalled result request changed");

  // Only the checksum result ends a frame.
  a_last_is_crc: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last == (kind == dmfm_pkg::KIND_CRC)))
    else $error("last and kind disagree");

  // Pixel words never carry the changed flag.
  a_pixel_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == dmfm_pkg::KIND_PIXEL) |-> !changed)
    else $error("changed set on a pixel word");

  // Out of reset the queue is empty and the input is open.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !result_valid && !raw_stall)
    else $error("not idle after reset");

endmodule

bind dot_matrix_frame_merger dmfm_checker u_dmfm_checker (
  .clk         (clk),
  .rst         (rst),
  .raw_valid   (raw_valid),
  .raw_stall   (raw_stall),
  .raw_word    (raw_word),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .kind        (kind),
  .data        (data),
  .changed     (changed),
  .last        (last)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for dot_matrix_frame_merger: random and directed frames, a
// word-by-word predictor of plane summing, sub-line weighting and the frame CRC.
// Depends on dmfm_pkg and the RTL in rtl/.
`timescale 1ns / 100ps

module tb_top;

  // Oversampling codes the package leaves unnamed.
  localparam logic [1:0] OVS_NONE   = 2'd0;
  localparam logic [1:0] OVS_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0] planes;
    logic       shift;
    logic [1:0] ovs;
    logic [4:0] wpl;
    logic [6:0] lines;
  } merge_cfg_t;

  // Effective frame shape after the block's clamping rules.
  typedef struct packed {
    int f;
    int np;
    int wpl;
    int pw;
  } geometry_t;

  localparam merge_cfg_t RESET_CFG = '{planes: 3'd1, shift: 1'b0, ovs: OVS_NONE,
                                       wpl: 5'd8, lines: 7'd32};

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_write;
  logic [dmfm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dmfm_pkg::CFG_W-1:0]     cfg_data;
  logic                           raw_valid;
  logic                           raw_stall;
  logic [31:0]                    raw_word;
  logic                           result_valid;
  logic                           result_stall;
  logic                           kind;
  logic [31:0]                    data;
  logic                           changed;
  logic                           last;

  dot_matrix_frame_merger uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .raw_valid(raw_valid), .raw_stall(raw_stall), .raw_word(raw_word),
    .result_valid(result_valid), .result_stall(result_stall),
    .kind(kind), .data(data), .changed(changed), .last(last)
  );

  always #4 clk = ~clk;

  // Words waiting to be sent, and results the predictor says are on their way.
  logic [31:0]       raw_backlog [$];
  dmfm_pkg::result_t awaited_results [$];

  int error_count = 0;
  bit raw_taken = 1'b0;
  bit result_taken = 1'b0;
  bit send_no_idle = 1'b0;
  bit recv_no_idle = 1'b0;
  bit hold_trigger = 1'b0;
  bit long_hold = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  // Predictor state.
  merge_cfg_t  cur_cfg;
  logic [31:0] plane_acc [dmfm_pkg::MAX_PLANE_WORDS];
  logic [31:0] line_acc [dmfm_pkg::MAX_LINE_WORDS];
  int          at_pos;
  int          at_plane;
  int          at_sub;
  int          at_col;
  logic [31:0] crc_acc;
  logic [31:0] last_frame_crc;

  task automatic note_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic geometry_t geometry_of(input merge_cfg_t c);
    geometry_t g;
    int nl;
    g.f = (c.ovs == dmfm_pkg::OVS_TWO) ? 2 : (c.ovs == dmfm_pkg::OVS_FOUR) ? 4 : 1;
    g.np = (c.planes == 0) ? 1 : int'(c.planes);
    if (g.np > dmfm_pkg::MAX_PLANES) g.np = dmfm_pkg::MAX_PLANES;
    g.wpl = (c.wpl == 0) ? 1 : int'(c.wpl);
    if (g.wpl > dmfm_pkg::MAX_LINE_WORDS) g.wpl = dmfm_pkg::MAX_LINE_WORDS;
    if (g.wpl > dmfm_pkg::MAX_PLANE_WORDS / g.f) g.wpl = dmfm_pkg::MAX_PLANE_WORDS / g.f;
    nl = (c.lines == 0) ? 1 : int'(c.lines);
    if (nl > dmfm_pkg::MAX_PLANE_WORDS / (g.wpl * g.f)) begin
      nl = dmfm_pkg::MAX_PLANE_WORDS / (g.wpl * g.f);
    end
    g.pw = g.wpl * nl * g.f;
    return g;
  endfunction

  // Reflected CRC-32 over the four bytes of a word, low byte first.
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc;
    for (int b = 0; b < 4; b++) begin
      c = c ^ {24'd0, w[8*b +: 8]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ dmfm_pkg::CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic void restart_frame();
    at_pos = 0;
    at_plane = 0;
    at_sub = 0;
    at_col = 0;
    crc_acc = dmfm_pkg::CRC_INIT;
  endfunction

  function automatic void apply_setting(input logic [dmfm_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [dmfm_pkg::CFG_W-1:0] val);
    case (idx)
      dmfm_pkg::REG_PLANES:         cur_cfg.planes = val[2:0];
      dmfm_pkg::REG_MERGE_SHIFT:    cur_cfg.shift = val[0];
      dmfm_pkg::REG_OVERSAMPLING:   cur_cfg.ovs = val[1:0];
      dmfm_pkg::REG_WORDS_PER_LINE: cur_cfg.wpl = val[4:0];
      dmfm_pkg::REG_LINES:          cur_cfg.lines = val[6:0];
      default:                      return;
    endcase
    // A write to any of registers 0 to 4 abandons the frame in progress.
    restart_frame();
  endfunction

  // Fold one raw word into the frame and queue the results it completes.
  task automatic merge_word(input logic [31:0] w);
    geometry_t   g;
    logic [31:0] v;
    logic [31:0] total;
    logic [31:0] wt;
    logic [31:0] word;
    logic [31:0] crc;
    bit          emit;
    g = geometry_of(cur_cfg);
    if (at_plane >= g.np || at_pos >= g.pw || at_sub >= g.f || at_col >= g.wpl) begin
      restart_frame();
    end
    v = cur_cfg.shift ? (w << at_plane) : w;
    total = (at_plane == 0) ? v : plane_acc[at_pos] + v;
    emit = 1'b0;
    word = '0;
    if (at_plane + 1 < g.np) begin
      plane_acc[at_pos] = total;
    end else if (g.f == 1) begin
      emit = 1'b1;
      word = total;
    end else begin
      // Sub-line weights: 2,1 for pairs and 2,4,1,8 for groups of four.
      if (g.f == 2) begin
        wt = (at_sub == 0) ? 32'd2 : 32'd1;
      end else begin
        case (at_sub)
          0:       wt = 32'd2;
          1:       wt = 32'd4;
          2:       wt = 32'd1;
          default: wt = 32'd8;
        endcase
      end
      line_acc[at_col] = (at_sub == 0) ? total * wt : line_acc[at_col] + total * wt;
      if (at_sub == g.f - 1) begin
        emit = 1'b1;
        word = line_acc[at_col];
      end
    end
    if (emit) begin
      crc_acc = crc_step(crc_acc, word);
      awaited_results.push_back('{kind: dmfm_pkg::KIND_PIXEL, data: word,
                                  changed: 1'b0, last: 1'b0});
    end

    // Advance the position counters; the end of the last plane closes the frame.
    at_col++;
    if (at_col == g.wpl) begin
      at_col = 0;
      at_sub++;
      if (at_sub == g.f) at_sub = 0;
    end
    at_pos++;
    if (at_pos == g.pw) begin
      at_pos = 0;
      at_sub = 0;
      at_col = 0;
      at_plane++;
      if (at_plane == g.np) begin
        crc = ~crc_acc;
        awaited_results.push_back('{kind: dmfm_pkg::KIND_CRC, data: crc,
                                    changed: (crc != last_frame_crc), last: 1'b1});
        last_frame_crc = crc;
        restart_frame();
      end
    end
  endtask

  task automatic check_result();
    dmfm_pkg::result_t want;
    if (awaited_results.size() == 0) begin
      note_mismatch($sformatf("result with none expected: kind %0b data %h", kind, data));
      return;
    end
    want = awaited_results.pop_front();
    if (kind !== want.kind)
      note_mismatch($sformatf("kind %0b, expected %0b", kind, want.kind));
    if (data !== want.data)
      note_mismatch($sformatf("data %h, expected %h", data, want.data));
    if (changed !== want.changed)
      note_mismatch($sformatf("changed %0b, expected %0b", changed, want.changed));
    if (last !== want.last)
      note_mismatch($sformatf("last %0b, expected %0b", last, want.last));
  endtask

  // Monitor: register writes, accepted requests on both sides.
  always @(posedge clk) begin
    raw_taken = 1'b0;
    result_taken = 1'b0;
    if (rst) begin
      cur_cfg = RESET_CFG;
      last_frame_crc = '0;
      restart_frame();
    end else begin
      if (cfg_write) apply_setting(cfg_index, cfg_data);
      if (raw_valid && !raw_stall) begin
        raw_taken = 1'b1;
        merge_word(raw_word);
      end
      if (result_valid && !result_stall) begin
        result_taken = 1'b1;
        check_result();
      end
    end
  end

  // Driver: one raw word per request, with a random gap after each.
  always @(negedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (!raw_valid || raw_taken) begin
      if (gap_left > 0) begin
        raw_valid <= 1'b0;
        gap_left--;
      end else if (raw_backlog.size() > 0) begin
        raw_word <= raw_backlog.pop_front();
        raw_valid <= 1'b1;
        gap_left = send_no_idle ? 0 : $urandom_range(0, 6);
      end else begin
        raw_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall after each result, plus the long hold when asked.
  always @(negedge clk) begin
    if (result_taken) stall_left = recv_no_idle ? 0 : $urandom_range(0, 6);
    if (rst) begin
      result_stall <= 1'b0;
    end else if (long_hold) begin
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Long receiver hold so the output queue fills and the input stalls.
  initial begin
    wait (hold_trigger);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("FAIL dot_matrix_frame_merger");
    $finish;
  end

  task automatic queue_words(input int n);
    logic [31:0] w;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0:       w = '0;
        1:       w = '1;
        2:       w = 32'h1 << $urandom_range(0, 31);
        default: w = $urandom;
      endcase
      raw_backlog.push_back(w);
    end
  endtask

  // Wait until every word is sent and every result is back, then let the
  // pipeline drain words that produce no result.
  task automatic settle();
    int waited;
    while (raw_backlog.size() != 0 || raw_valid) @(posedge clk);
    waited = 0;
    while (awaited_results.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_results.size() != 0) begin
      note_mismatch($sformatf("%0d expected results never arrived", awaited_results.size()));
      awaited_results.delete();
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input dmfm_pkg::cfg_reg_t idx,
                           input logic [dmfm_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Unused upper data bits carry junk to check that narrow registers mask it.
  task automatic apply_settings(input merge_cfg_t c);
    logic [dmfm_pkg::CFG_W-1:0] junk;
    settle();
    junk = dmfm_pkg::CFG_W'($urandom);
    write_reg(dmfm_pkg::REG_PLANES, {junk[6:3], c.planes});
    write_reg(dmfm_pkg::REG_MERGE_SHIFT, {junk[6:1], c.shift});
    write_reg(dmfm_pkg::REG_OVERSAMPLING, {junk[6:2], c.ovs});
    write_reg(dmfm_pkg::REG_WORDS_PER_LINE, {junk[6:5], c.wpl});
    write_reg(dmfm_pkg::REG_LINES, c.lines);
  endtask

  initial begin
    merge_cfg_t  c;
    geometry_t   g;
    logic [31:0] x;
    logic [31:0] zero_word;
    logic        b;
    int          random_items;
    int          frames;
    int          fw;
    int          part;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = dmfm_pkg::REG_PLANES;
    cfg_data = '0;
    raw_valid = 1'b0;
    raw_word = '0;
    result_stall = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a partial frame that the first register write abandons.
    queue_words(6);

    // Single-word frames. Run the CRC backward to find the word whose
    // checksum is zero, so the first frame reports no change.
    x = '1;
    repeat (32) begin
      b = x[31];
      x = ((x ^ (b ? dmfm_pkg::CRC_POLY : 32'd0)) << 1) | {31'd0, b};
    end
    zero_word = ~x;
    apply_settings('{planes: 3'd1, shift: 1'b0, ovs: OVS_NONE, wpl: 5'd1, lines: 7'd1});
    raw_backlog.push_back(zero_word);
    raw_backlog.push_back(zero_word);
    raw_backlog.push_back('1);

    // Four shifted planes of all ones.
    apply_settings('{planes: 3'd4, shift: 1'b1, ovs: OVS_NONE, wpl: 5'd1, lines: 7'd1});
    repeat (4) raw_backlog.push_back('1);

    // Two planes over two sub-lines.
    apply_settings('{planes: 3'd2, shift: 1'b0, ovs: dmfm_pkg::OVS_TWO, wpl: 5'd1,
                     lines: 7'd1});
    queue_words(4);

    // Four sub-lines of all ones, wrapping the weighted sum.
    apply_settings('{planes: 3'd1, shift: 1'b0, ovs: dmfm_pkg::OVS_FOUR, wpl: 5'd1,
                     lines: 7'd1});
    repeat (4) raw_backlog.push_back('1);

    // Zero planes, words and lines with the unused oversampling code.
    apply_settings('{planes: 3'd0, shift: 1'b0, ovs: OVS_UNUSED, wpl: 5'd0, lines: 7'd0});
    queue_words(1);

    // Largest line and line count, clamped to the memory size: the start of
    // a plane sent back to back, which the next register write abandons.
    c = '{planes: 3'd1, shift: 1'b0, ovs: dmfm_pkg::OVS_FOUR, wpl: 5'd31, lines: 7'd127};
    apply_settings(c);
    send_no_idle = 1'b1;
    recv_no_idle = 1'b1;
    queue_words(256);

    // Receiver holds off while the sender keeps going.
    apply_settings('{planes: 3'd1, shift: 1'b0, ovs: OVS_NONE, wpl: 5'd8, lines: 7'd40});
    queue_words(320);
    hold_trigger = 1'b1;
    // Words queued by the directed cases so far.
    random_items = 598;

    // Random settings, mostly whole frames, some cut short.
    while (random_items < 1300) begin
      c.planes = 3'($urandom_range(0, 7));
      c.shift = 1'($urandom_range(0, 1));
      c.ovs = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) begin
        c.wpl = 5'($urandom_range(20, 31));
        c.lines = 7'($urandom_range(0, 2));
      end else begin
        c.wpl = 5'($urandom_range(0, 6));
        c.lines = 7'($urandom_range(0, 4));
      end
      g = geometry_of(c);
      fw = g.np * g.pw;
      frames = (fw > 300) ? 1 : $urandom_range(1, 3);
      apply_settings(c);
      send_no_idle = ($urandom_range(0, 4) == 0);
      recv_no_idle = ($urandom_range(0, 4) == 0);
      queue_words(frames * fw);
      random_items += frames * fw;
      if (fw > 1 && $urandom_range(0, 3) == 0) begin
        part = $urandom_range(1, fw - 1);
        queue_words(part);
        random_items += part;
      end
    end

    settle();
    if (error_count == 0) begin
      $display("PASS dot_matrix_frame_merger");
    end else begin
      $display("FAIL dot_matrix_frame_merger");
    end
    $finish;
  end

endmodule
